>>> rtl/lac_pkg.sv
package lac_pkg;

  localparam int SAMPLE_BITS = 12;
  localparam int MAX_LAGS_DEF = 64;
  localparam int NUM_CH = 3;
  localparam int CNT_BITS = 20;

  localparam logic [1:0] CH_NONE = 2'd3;
  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_READ = 1'b1;

  typedef logic signed [SAMPLE_BITS-1:0] samp_t;
  typedef samp_t [NUM_CH-1:0] trio_t;

  typedef struct packed {
    logic vld;
    logic rd;
    logic [1:0] ch;
    logic [5:0] lag;
    trio_t x;
  } tok_t;

  typedef struct packed {
    logic [CNT_BITS-1:0] pc;
    logic [62:0] sf;
    logic signed [43:0] sp;
    logic signed [31:0] sd;
    logic signed [31:0] sc;
  } res_t;

endpackage

>>> rtl/lac_cell.sv
module lac_cell
  import lac_pkg::*;
#(
  parameter int CELL_IDX = 0,
  parameter int LW = 7
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          shift_en,
  input  trio_t         tap_in,
  output trio_t         tap_out,
  input  tok_t          tok_in,
  output tok_t          tok_out,
  input  logic [LW-1:0] n_in,
  input  res_t          bus_in,
  output res_t          bus_out
);

  trio_t tap_r;
  tok_t tok_r;
  res_t bus_r;

  logic v1_r, v2_r;
  samp_t x1_r [NUM_CH];
  samp_t y1_r [NUM_CH];
  logic signed [2*SAMPLE_BITS-1:0] p1_r [NUM_CH];
  samp_t x2_r [NUM_CH];
  samp_t y2_r [NUM_CH];
  logic signed [2*SAMPLE_BITS-1:0] p2_r [NUM_CH];
  logic [4*SAMPLE_BITS-1:0] q2_r [NUM_CH];

  logic signed [31:0] sc_r [NUM_CH];
  logic signed [31:0] sd_r [NUM_CH];
  logic signed [43:0] sp_r [NUM_CH];
  logic [62:0] sf_r [NUM_CH];
  logic [CNT_BITS-1:0] pc_r;

  logic signed [31:0] sc_nxt [NUM_CH];
  logic signed [31:0] sd_nxt [NUM_CH];
  logic signed [43:0] sp_nxt [NUM_CH];
  logic [62:0] sf_nxt [NUM_CH];
  logic [2*SAMPLE_BITS-1:0] ap [NUM_CH];
  logic en, hit;
  res_t sel;

  assign en = tok_r.vld && !tok_r.rd && (CELL_IDX < int'(n_in));
  assign hit = tok_r.vld && tok_r.rd && (int'(tok_r.lag) == CELL_IDX);

  always_comb begin
    logic signed [32:0] tc, td;
    logic signed [44:0] tp;
    logic [63:0] tf;
    for (int c = 0; c < NUM_CH; c++) begin
      ap[c] = p1_r[c][2*SAMPLE_BITS-1] ? (2*SAMPLE_BITS)'(-p1_r[c]) : p1_r[c];
      tc = 33'(sc_r[c]) + 33'(x2_r[c]);
      td = 33'(sd_r[c]) + 33'(y2_r[c]);
      tp = 45'(sp_r[c]) + 45'(p2_r[c]);
      tf = {1'b0, sf_r[c]} + 64'(q2_r[c]);
      sc_nxt[c] = (tc[32] != tc[31]) ? {tc[32], {31{~tc[32]}}} : tc[31:0];
      sd_nxt[c] = (td[32] != td[31]) ? {td[32], {31{~td[32]}}} : td[31:0];
      sp_nxt[c] = (tp[44] != tp[43]) ? {tp[44], {43{~tp[44]}}} : tp[43:0];
      sf_nxt[c] = tf[63] ? {63{1'b1}} : tf[62:0];
    end
  end

  always_comb begin
    sel = '0;
    sel.pc = pc_r;
    if (tok_r.ch != CH_NONE) begin
      sel.sc = sc_r[tok_r.ch];
      sel.sd = sd_r[tok_r.ch];
      sel.sp = sp_r[tok_r.ch];
      sel.sf = sf_r[tok_r.ch];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.vld <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      pc_r <= '0;
      for (int c = 0; c < NUM_CH; c++) begin
        sc_r[c] <= '0;
        sd_r[c] <= '0;
        sp_r[c] <= '0;
        sf_r[c] <= '0;
      end
    end else begin
      tok_r <= tok_in;
      v1_r <= en;
      v2_r <= v1_r;
      if (v2_r) begin
        if (pc_r != {CNT_BITS{1'b1}}) begin
          pc_r <= pc_r + 1'b1;
        end
        for (int c = 0; c < NUM_CH; c++) begin
          sc_r[c] <= sc_nxt[c];
          sd_r[c] <= sd_nxt[c];
          sp_r[c] <= sp_nxt[c];
          sf_r[c] <= sf_nxt[c];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (shift_en) begin
      tap_r <= tap_in;
    end
    bus_r <= hit ? sel : bus_in;
    for (int c = 0; c < NUM_CH; c++) begin
      x1_r[c] <= tok_r.x[c];
      y1_r[c] <= tap_r[c];
      p1_r[c] <= $signed(tok_r.x[c]) * $signed(tap_r[c]);
      x2_r[c] <= x1_r[c];
      y2_r[c] <= y1_r[c];
      p2_r[c] <= p1_r[c];
      q2_r[c] <= 48'(ap[c]) * 48'(ap[c]);
    end
  end

  assign tap_out = tap_r;
  assign tok_out = tok_r;
  assign bus_out = bus_r;

endmodule

>>> rtl/lag_autocorrelation_accumulator_top.sv
// Lag autocorrelation accumulator.
// in_* channel: one item per push or read. in_tuser carries cmd (0 push, 1 read);
// a push delivers three signed samples, a read names a channel and a lag.
// out_* channel: one item per read carrying the four sums and the pair count.
// cfg_* channel: writes lag_count; this restarts the delay line (samples seen
// go to zero) and keeps the accumulators. cfg_ready is always high, and
// in_tready is low in any cycle in which cfg_valid is high.
// Every item walks a row of MAX_LAGS cells, one cell per cycle, each cell
// owning one lag. A push occupies the block for the walk plus the
// multiply, square and accumulate stages of the last cell; a read occupies
// it alike, and its result is captured from the end of the row before the
// block frees. No new item is accepted until the previous one is through.
// A finished result waits in the output register; a second one waits in a
// hold register, and only then does in_tready stay low until the receiver
// takes the first. Reset (rst_n low, synchronous) zeroes all sums and counts
// and sets lag_count to 64; no clearing pass is needed.
module lag_autocorrelation_accumulator_top
  import lac_pkg::*;
#(
  parameter int MAX_LAGS = MAX_LAGS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [47:0]  in_tdata,   // sample_a, sample_b, sample_c, channel, lag, zero pad
  input  logic         in_tuser,   // cmd
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [191:0] out_tdata,  // sum_current, sum_delayed, sum_products, sum_fourth,
                                   // pair_count, zero pad
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [6:0]   cfg_data
);

  localparam int LW = $clog2(MAX_LAGS + 1);
  localparam int CW = $clog2(MAX_LAGS + 3);
  localparam logic [CW-1:0] CAPTURE = CW'(MAX_LAGS);
  localparam logic [CW-1:0] DONE = CW'(MAX_LAGS + 2);

  logic [6:0] lag_count_r;
  logic [CNT_BITS-1:0] seen_r;
  logic [CNT_BITS-1:0] seen_nxt;
  logic [LW-1:0] n_r;
  logic [LW-1:0] eff;
  logic busy_r, rd_r, res_pend_r, out_valid_r;
  logic [CW-1:0] cnt_r;
  res_t res_r, out_r;
  logic in_acc, push_acc, out_load;

  tok_t tok_w [MAX_LAGS+1];
  trio_t tap_w [MAX_LAGS+1];
  res_t bus_w [MAX_LAGS+1];

  assign in_tready = !busy_r && !res_pend_r && !cfg_valid;
  assign cfg_ready = 1'b1;
  assign in_acc = in_tvalid && in_tready;
  assign push_acc = in_acc && (in_tuser == CMD_PUSH);
  assign out_load = res_pend_r && (!out_valid_r || out_tready);

  always_comb begin
    if (lag_count_r == 7'd0) begin
      eff = LW'(1);
    end else if (int'(lag_count_r) > MAX_LAGS) begin
      eff = LW'(MAX_LAGS);
    end else begin
      eff = LW'(lag_count_r);
    end
    seen_nxt = (seen_r == {CNT_BITS{1'b1}}) ? seen_r : seen_r + 1'b1;
  end

  assign tok_w[0] = '{vld: in_acc, rd: in_tuser, ch: in_tdata[37:36], lag: in_tdata[43:38],
                      x: in_tdata[35:0]};
  assign tap_w[0] = in_tdata[35:0];
  assign bus_w[0] = '0;

  for (genvar i = 0; i < MAX_LAGS; i++) begin : g_cell
    lac_cell #(.CELL_IDX(i), .LW(LW)) u_cell (
      .clk(clk), .rst_n(rst_n), .shift_en(push_acc),
      .tap_in(tap_w[i]), .tap_out(tap_w[i+1]),
      .tok_in(tok_w[i]), .tok_out(tok_w[i+1]),
      .n_in(n_r), .bus_in(bus_w[i]), .bus_out(bus_w[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lag_count_r <= 7'd64;
      seen_r <= '0;
      n_r <= '0;
      busy_r <= 1'b0;
      rd_r <= 1'b0;
      cnt_r <= '0;
      res_pend_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        lag_count_r <= cfg_data;
        seen_r <= '0;
      end else if (push_acc) begin
        seen_r <= seen_nxt;
        n_r <= (seen_nxt < CNT_BITS'(eff)) ? LW'(seen_nxt) : eff;
      end
      if (in_acc) begin
        busy_r <= 1'b1;
        rd_r <= (in_tuser == CMD_READ);
        cnt_r <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DONE) begin
          busy_r <= 1'b0;
        end
      end
      if (busy_r && rd_r && cnt_r == CAPTURE) begin
        res_pend_r <= 1'b1;
      end else if (out_load) begin
        res_pend_r <= 1'b0;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy_r && rd_r && cnt_r == CAPTURE) begin
      res_r <= bus_w[MAX_LAGS];
    end
    if (out_load) begin
      out_r <= res_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata = {1'b0, out_r};

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> busy_r && !in_tready)
    else $error("block not busy after accepting an item");

  a_capture_read_only: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(res_pend_r) |-> $past(rd_r) && $past(busy_r))
    else $error("result captured for a push");

  a_pending_holds: assert property (@(posedge clk) disable iff (!rst_n)
    res_pend_r && out_valid_r && !out_tready |=> res_pend_r && $stable(res_r))
    else $error("pending result lost while output stalled");

endmodule

>>> tb/lag_autocorrelation_accumulator_checker.sv
module lag_autocorrelation_accumulator_checker
  import lac_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [47:0]  in_tdata,
  input  logic         in_tuser,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [191:0] out_tdata,
  input  logic         cfg_valid,
  input  logic         cfg_ready,
  input  logic [6:0]   cfg_data,
  output int           fail_count,
  output int           pending_reads,
  output int           reads_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NL = 64;
  localparam longint S32_HI = 64'sd2147483647;
  localparam longint S32_LO = -64'sd2147483648;
  localparam longint S44_HI = 64'sd8796093022207;
  localparam longint S44_LO = -64'sd8796093022208;
  localparam logic [63:0] U63_HI = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam int CNT_HI = 1048575;

  logic [6:0] lag_reg;
  int ring [NL][3];
  int wpos;
  int seen;
  longint cur_acc [3][NL];
  longint del_acc [3][NL];
  longint prod_acc [3][NL];
  logic [63:0] quad_acc [3][NL];
  int pairs [NL];
  res_t sums_due [$];

  function automatic longint clamp(longint v, longint lo, longint hi);
    return v > hi ? hi : (v < lo ? lo : v);
  endfunction

  function automatic int span();
    if (lag_reg == 0) return 1;
    if (lag_reg > NL) return NL;
    return lag_reg;
  endfunction

  task automatic absorb_samples(trio_t x);
    int l, pos, n, p2;
    longint a, b, p, ap;
    logic [63:0] q;
    l = span();
    pos = wpos < l ? wpos : 0;
    for (int c = 0; c < 3; c++) ring[pos][c] = int'(x[c]);
    if (seen < CNT_HI) seen++;
    n = seen < l ? seen : l;
    for (int i = 0; i < n; i++) begin
      p2 = (pos + l - i) % l;
      for (int c = 0; c < 3; c++) begin
        a = ring[pos][c];
        b = ring[p2][c];
        p = a * b;
        ap = p < 0 ? -p : p;
        q = ap * ap;
        cur_acc[c][i] = clamp(cur_acc[c][i] + a, S32_LO, S32_HI);
        del_acc[c][i] = clamp(del_acc[c][i] + b, S32_LO, S32_HI);
        prod_acc[c][i] = clamp(prod_acc[c][i] + p, S44_LO, S44_HI);
        quad_acc[c][i] = (q > U63_HI - quad_acc[c][i]) ? U63_HI : quad_acc[c][i] + q;
      end
      if (pairs[i] < CNT_HI) pairs[i]++;
    end
    wpos = (pos + 1) % l;
  endtask

  function automatic res_t lookup(logic [1:0] ch, logic [5:0] lg);
    res_t r;
    r = '0;
    if (ch != CH_NONE) begin
      r.sc = cur_acc[ch][lg][31:0];
      r.sd = del_acc[ch][lg][31:0];
      r.sp = prod_acc[ch][lg][43:0];
      r.sf = quad_acc[ch][lg][62:0];
    end
    r.pc = pairs[lg][19:0];
    return r;
  endfunction

  assign pending_reads = sums_due.size();

  always @(posedge clk) begin
    trio_t x;
    res_t got, want;
    if (!rst_n) begin
      lag_reg = 7'd64;
      wpos = 0;
      seen = 0;
      fail_count = 0;
      reads_seen = 0;
      sums_due.delete();
      for (int c = 0; c < 3; c++)
        for (int i = 0; i < NL; i++) begin
          cur_acc[c][i] = 0; del_acc[c][i] = 0; prod_acc[c][i] = 0; quad_acc[c][i] = 0;
        end
      for (int i = 0; i < NL; i++) pairs[i] = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = res_t'(out_tdata[190:0]);
        reads_seen++;
        if (sums_due.size() == 0) begin
          $display("%0t: result with nothing expected, actual %h", $time, got);
          fail_count++;
        end else begin
          want = sums_due.pop_front();
          if (got.sc !== want.sc || got.sd !== want.sd || got.sp !== want.sp ||
              got.sf !== want.sf || got.pc !== want.pc || out_tdata[191] !== 1'b0) begin
            $display("%0t: mismatch expected sc=%0d sd=%0d sp=%0d sf=%0d pc=%0d", $time,
                     want.sc, want.sd, want.sp, want.sf, want.pc);
            $display("%0t:          actual   sc=%0d sd=%0d sp=%0d sf=%0d pc=%0d", $time,
                     got.sc, got.sd, got.sp, got.sf, got.pc);
            fail_count++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        lag_reg = cfg_data;
        wpos = 0;
        seen = 0;
      end
      if (in_tvalid && in_tready) begin
        if (in_tuser == CMD_PUSH) begin
          x = trio_t'(in_tdata[35:0]);
          absorb_samples(x);
        end else begin
          sums_due.push_back(lookup(in_tdata[37:36], in_tdata[43:38]));
        end
      end
    end
  end
endmodule

>>> tb/lag_autocorrelation_accumulator_top_test.sv
module lag_autocorrelation_accumulator_top_test
  import lac_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET = 80;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [47:0]  in_tdata;
  logic         in_tuser;
  logic         out_tvalid;
  logic         out_tready;
  logic [191:0] out_tdata;
  logic         cfg_valid;
  logic         cfg_ready;
  logic [6:0]   cfg_data;
  int           fail_count;
  int           pending_reads;
  int           reads_seen;
  bit           hold_off;

  lag_autocorrelation_accumulator_top dut (.*);

  lag_autocorrelation_accumulator_checker chk (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 150);
  endfunction

  initial begin
    out_tready = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_off) begin
        out_tready <= 1'b0;
        repeat (600) @(posedge clk);
        hold_off = 1'b0;
      end
      out_tready <= 1'b1;
      @(posedge clk);
      if ($urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat (gap_len() + 1) @(posedge clk);
      end
    end
  end

  task automatic send(logic cmd, logic [11:0] a, logic [11:0] b, logic [11:0] c,
                      logic [1:0] ch, logic [5:0] lg);
    in_tvalid <= 1'b1;
    in_tuser <= cmd;
    in_tdata <= {4'b0, lg, ch, c, b, a};
    @(posedge clk iff in_tready);
    if ($urandom_range(0, 2) == 0) begin
      in_tvalid <= 1'b0;
      repeat (gap_len() + 1) @(posedge clk);
    end
  endtask

  task automatic push_rand();
    int m;
    logic [11:0] s [3];
    m = $urandom_range(0, 3);
    for (int k = 0; k < 3; k++)
      case (m)
        0: s[k] = $urandom_range(0, 1) ? 12'h7FF : 12'h800;
        1: s[k] = 12'($urandom_range(0, 15) - 8);
        default: s[k] = 12'($urandom);
      endcase
    send(CMD_PUSH, s[0], s[1], s[2], 2'd0, 6'd0);
  endtask

  task automatic read_rand();
    send(CMD_READ, 12'($urandom), 12'($urandom), 12'($urandom),
         2'($urandom_range(0, 3)), 6'($urandom));
  endtask

  task automatic set_lags(logic [6:0] v);
    in_tvalid <= 1'b0;
    wait (pending_reads == 0);
    repeat (QUIET) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk iff cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [6:0] lag_set [6];
    lag_set = '{7'd1, 7'd0, 7'd3, 7'd127, 7'd64, 7'd17};
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = CMD_PUSH;
    cfg_valid = 1'b0;
    cfg_data = '0;
    hold_off = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send(CMD_PUSH, 12'h7FF, 12'h800, 12'h000, 2'd0, 6'd0);
    send(CMD_PUSH, 12'h800, 12'h7FF, 12'hFFF, 2'd0, 6'd0);
    send(CMD_PUSH, 12'h800, 12'h800, 12'h001, 2'd0, 6'd0);
    for (int c = 0; c < 4; c++) send(CMD_READ, 12'hFFF, 12'hFFF, 12'hFFF, 2'(c), 6'd0);
    send(CMD_READ, '0, '0, '0, 2'd0, 6'd1);
    send(CMD_READ, '0, '0, '0, 2'd2, 6'd2);
    send(CMD_READ, '0, '0, '0, 2'd1, 6'd63);
    send(CMD_READ, '0, '0, '0, 2'd3, 6'd63);
    set_lags(7'd2);
    for (int i = 0; i < 4; i++)
      send(CMD_PUSH, 12'h7FF, 12'h800, 12'h555, 2'd0, 6'd0);
    for (int g = 0; g < 3; g++) send(CMD_READ, '0, '0, '0, 2'd0, 6'(g));
    send(CMD_READ, '0, '0, '0, 2'd2, 6'd1);
    hold_off = 1'b1;
    for (int i = 0; i < 6; i++) read_rand();
    foreach (lag_set[k]) begin
      set_lags(lag_set[k]);
      for (int i = 0; i < 88; i++) begin
        if ($urandom_range(0, 2) == 0) read_rand();
        else push_rand();
      end
    end
    in_tvalid <= 1'b0;
    wait (pending_reads == 0);
    repeat (QUIET) @(posedge clk);
    $display("Covered pushes and reads over lag settings 0,1,2,3,17,64,127,");
    $display("with %0d reads checked, including saturating samples.", reads_seen);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
